@@ hdl/forest_fire_automaton_step_core_macros.svh @@
// Assertion macros shared by the forest-fire step core.
`ifndef FOREST_FIRE_AUTOMATON_STEP_CORE_MACROS_SVH
`define FOREST_FIRE_AUTOMATON_STEP_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ffa_pkg.sv @@
// Types, constants and the cell update function of the forest-fire step core.
`default_nettype none

package ffa_pkg;

    localparam int CELL_W      = 9;
    localparam int ROLL_W      = 14;
    localparam int COLUMN_W    = 3 * CELL_W;
    localparam int ROLLS_W     = 2 * ROLL_W;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CELL_W-1:0] CODE_EMPTY     = 9'd0;
    localparam logic [CELL_W-1:0] CODE_TREE      = 9'd1;
    localparam logic [CELL_W-1:0] CODE_FULL_HEAT = 9'd256;

    // Heat decay: floor(heat * 5 / 6) == (heat * 3415) >> 12 for heat <= 255.
    localparam logic [11:0] DECAY_MUL   = 12'd3415;
    localparam int          DECAY_SHIFT = 12;

    localparam logic [ROLL_W-1:0] GROW_THR_RESET   = 14'd7;
    localparam logic [ROLL_W-1:0] IGNITE_THR_RESET = 14'd1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_GROW_THRESHOLD   = 1'b0,
        CFG_IGNITE_THRESHOLD = 1'b1
    } t_cfg_index;

    typedef logic [COLUMN_W-1:0] t_column;   // top (low), mid, bottom (high)
    typedef logic [ROLLS_W-1:0]  t_rolls;    // grow roll (low), ignite roll (high)

    typedef struct packed {
        logic [ROLL_W-1:0] grow_thr;
        logic [ROLL_W-1:0] ignite_thr;
    } t_cfg;

    // Work handed from the front to the back for one accepted beat.
    typedef struct packed {
        t_column left_a;    // window of the pending centre cell
        t_column centre_a;
        t_rolls  rolls_a;
        t_column col;       // incoming column: right of A, centre of B
        t_rolls  rolls_b;
        logic    emit_a;    // pending centre cell gets its result
        logic    emit_b;    // incoming column closes the row
    } t_job;

    function automatic logic [CELL_W-1:0] cell_of(input t_column c, input int row);
        return c[row*CELL_W +: CELL_W];
    endfunction

    // Any code at or above full heat counts as a full-heat neighbor.
    function automatic logic column_hot(input t_column c);
        return c[CELL_W-1] | c[2*CELL_W-1] | c[3*CELL_W-1];
    endfunction

    function automatic logic [CELL_W-1:0] next_cell(
        input t_column left,
        input t_column centre,
        input t_column right,
        input t_rolls  rolls,
        input t_cfg    cfg
    );
        logic [CELL_W-1:0] c;
        logic [7:0]        heat;
        logic [19:0]       prod;
        logic [7:0]        cooled;
        logic              hot;
        logic [CELL_W-1:0] res;
        c      = cell_of(centre, 1);
        heat   = c[CELL_W-1] ? 8'd255 : 8'(c - 9'd1);
        prod   = 20'(heat) * 20'(DECAY_MUL);
        cooled = prod[DECAY_SHIFT +: 8];
        // Top and bottom cells of the centre column are the top bits of their slots.
        hot    = column_hot(left) | column_hot(right)
               | centre[CELL_W-1] | centre[3*CELL_W-1];
        if (c == CODE_EMPTY) begin
            res = (rolls[ROLL_W-1:0] < cfg.grow_thr) ? CODE_TREE : CODE_EMPTY;
        end else if (c == CODE_TREE) begin
            res = (hot || (rolls[ROLLS_W-1:ROLL_W] < cfg.ignite_thr))
                ? CODE_FULL_HEAT : CODE_TREE;
        end else begin
            res = (cooled == 8'd0) ? CODE_EMPTY : (CELL_W'(cooled) + 9'd1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/forest_fire_automaton_step_core.sv @@
// Top level of the forest-fire step core: config registers, front, queue, back.
//
// One generation of a forest-fire automaton, streamed one grid column per beat.
// Slave channel: each beat carries the old top, middle and bottom cells of one
// column plus the grow and ignite rolls of the middle cell; tuser marks the
// first column of a row and tlast the last one. Master channel: one beat per
// new middle cell, tlast set on the last cell of a row.
// A column beat after a row's first yields the new cell of the previous column; the last
// column of a row yields that cell and its own, so a row of N columns gives N beats.
// A result passes through the job queue and then the back end's result register once the
// beat that completes its window is taken. Throughput: one column per cycle while the
// queue is not full; a row-end job gives the back end two results in turn, absorbed by the job queue.
// The back end's single result register, one result per cycle unless the receiver stalls, sets the rate.
// When the receiver stalls, results hold in the output register and jobs fill
// the queue; tready drops once the queue is full.
// Reset (synchronous, active low) clears the window, queue and output valid,
// and sets the thresholds to grow 7 and ignite 1.
// The user writes thresholds through the config port only while the core is idle; the core does not enforce this.
`default_nettype none
`include "forest_fire_automaton_step_core_macros.svh"

module forest_fire_automaton_step_core #(
    parameter int QUEUE_DEPTH = ffa_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port.
    input  wire logic                          i_cfg_wen,
    input  wire logic [0:0]                    i_cfg_addr,
    input  wire logic [ffa_pkg::ROLL_W-1:0]    i_cfg_wdata,
    // Column stream in.
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    // tdata: top_cell[8:0], mid_cell[17:9], bottom_cell[26:18],
    //        grow_roll[40:27], ignite_roll[54:41], zero[55]
    input  wire logic [ffa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: first_column[0]
    input  wire logic                          s_axis_tuser,
    input  wire logic                          s_axis_tlast,
    // Cell stream out.
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: new_cell[8:0], zero[15:9]
    output      logic [ffa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output      logic                          m_axis_tlast
);

    ffa_pkg::t_cfg              r_cfg;
    ffa_pkg::t_job              push_job;
    ffa_pkg::t_job              head_job;
    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_valid;
    logic [ffa_pkg::CELL_W-1:0] new_cell;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grow_thr   <= ffa_pkg::GROW_THR_RESET;
            r_cfg.ignite_thr <= ffa_pkg::IGNITE_THR_RESET;
        end else if (i_cfg_wen) begin
            unique case (ffa_pkg::t_cfg_index'(i_cfg_addr))
                ffa_pkg::CFG_GROW_THRESHOLD:   r_cfg.grow_thr   <= i_cfg_wdata;
                ffa_pkg::CFG_IGNITE_THRESHOLD: r_cfg.ignite_thr <= i_cfg_wdata;
            endcase
        end
    end

    ffa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_first      (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    ffa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    ffa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_cell      (new_cell),
        .o_row_end   (m_axis_tlast)
    );

    assign m_axis_tdata = {(ffa_pkg::M_TDATA_W - ffa_pkg::CELL_W)'(0), new_cell};

    // A row-end beat always leaves work queued for the back end.
    `FFA_ASSERT_NEXT(a_last_queued, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, q_valid, "row-end beat left no queued job")
    // Backpressure on the input only when the queue holds work.
    `FFA_ASSERT_NOW(a_stall_has_work, i_clk, i_rst_n, !s_axis_tready, q_valid, "input stalled with an empty queue")
    // Every emitted code is a legal cell code.
    `FFA_ASSERT_NOW(a_code_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata <= ffa_pkg::M_TDATA_W'(ffa_pkg::CODE_FULL_HEAT), "new cell code above full heat")

endmodule

`default_nettype wire

@@ hdl/ffa_front.sv @@
// Front part: accepts column beats, keeps the window and classifies the work.
`default_nettype none

module ffa_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output      logic                        o_ready,
    input  wire logic [ffa_pkg::S_TDATA_W-1:0] i_data,
    input  wire logic                        i_first,
    input  wire logic                        i_last,
    input  wire logic                        i_queue_full,
    output      logic                        o_push,
    output      ffa_pkg::t_job               o_job
);

    logic             r_held;
    ffa_pkg::t_column r_left;
    ffa_pkg::t_column r_centre;
    ffa_pkg::t_rolls  r_rolls;

    logic             accept;
    logic             take_mid;
    ffa_pkg::t_column col;
    ffa_pkg::t_rolls  rolls;

    assign o_ready  = !i_queue_full;
    assign accept   = i_valid && o_ready;
    assign col      = i_data[ffa_pkg::COLUMN_W-1:0];
    assign rolls    = i_data[ffa_pkg::COLUMN_W +: ffa_pkg::ROLLS_W];
    // A pending centre resolves unless the beat starts a new row.
    assign take_mid = r_held && !i_first;

    // Classify the beat into zero, one or two results.
    always_comb begin
        o_job.left_a   = r_left;
        o_job.centre_a = r_centre;
        o_job.rolls_a  = r_rolls;
        o_job.col      = col;
        o_job.rolls_b  = rolls;
        o_job.emit_a   = take_mid;
        o_job.emit_b   = i_last;
        o_push         = accept && (take_mid || i_last);
    end

    // Window state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (accept) begin
            r_held <= !i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left   <= take_mid ? r_centre : '0;
            r_centre <= col;
            r_rolls  <= rolls;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ffa_queue.sv @@
// Short job queue between the front and the back.
`default_nettype none

module ffa_queue #(
    parameter int DEPTH = ffa_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ffa_pkg::t_job i_job,
    input  wire logic          i_pop,
    output      logic          o_full,
    output      logic          o_valid,
    output      ffa_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ffa_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ffa_back.sv @@
// Back part: evaluates queued jobs and drives the result register.
`default_nettype none

module ffa_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ffa_pkg::t_cfg i_cfg,
    input  wire logic          i_job_valid,
    input  wire ffa_pkg::t_job i_job,
    output      logic          o_pop,
    output      logic          o_valid,
    input  wire logic          i_ready,
    output      logic [ffa_pkg::CELL_W-1:0] o_cell,
    output      logic          o_row_end
);

    logic                       r_second;
    logic                       r_valid;
    logic [ffa_pkg::CELL_W-1:0] r_cell;
    logic                       r_row_end;

    logic                       load;
    logic                       do_a;
    logic                       final_beat;
    ffa_pkg::t_column           left;
    ffa_pkg::t_column           centre;
    ffa_pkg::t_column           right;
    ffa_pkg::t_rolls            rolls;
    logic [ffa_pkg::CELL_W-1:0] new_cell;

    // Pick the pending-centre result first, then the row-end result.
    always_comb begin
        do_a = i_job.emit_a && !r_second;
        if (do_a) begin
            left       = i_job.left_a;
            centre     = i_job.centre_a;
            right      = i_job.col;
            rolls      = i_job.rolls_a;
            final_beat = !i_job.emit_b;
        end else begin
            left       = i_job.emit_a ? i_job.centre_a : '0;
            centre     = i_job.col;
            right      = '0;
            rolls      = i_job.rolls_b;
            final_beat = 1'b1;
        end
        new_cell = ffa_pkg::next_cell(left, centre, right, rolls, i_cfg);
    end

    assign load  = i_job_valid && (!r_valid || i_ready);
    assign o_pop = load && final_beat;

    // Control: phase within a job and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_second <= !final_beat;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cell    <= new_cell;
            r_row_end <= !do_a;
        end
    end

    assign o_valid   = r_valid;
    assign o_cell    = r_cell;
    assign o_row_end = r_row_end;

endmodule

`default_nettype wire
